FILE: rtl/cmo_pkg.sv
// ----------------------------------------------------------------------------
// cmo_pkg: shared definitions of the circular motion oscillator
// Field widths, register indexes, state types, queue entry and the
// arctangent table of the rotation unit.
// ----------------------------------------------------------------------------
package cmo_pkg;

   localparam int PHASE_BITS_DEF = 32;
   localparam int TRIG_BITS_DEF  = 16;

   localparam int DELTA_W     = 16;
   localparam int STEP_W      = 32;
   localparam int AMP_W       = 12;
   localparam int OFFSET_W    = 16;
   localparam int POS_W       = 17;
   localparam int ANGLE_W     = 16;
   localparam int TURN_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TURN_W-1:0] CORDIC_GAIN_Q32 = 32'h9B74_EDA8;
   localparam int POS_LIMIT = 65520;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP   = 3'd0,
      CSR_AMPLITUDE    = 3'd1,
      CSR_PHASE_OFFSET = 3'd2,
      CSR_CLOCKWISE    = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_ACC,
      F_ANG,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ROT,
      B_MULS,
      B_MULC,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [STEP_W-1:0]   phase_step;
      logic [OFFSET_W-1:0] phase_offset;
      logic                clockwise;
   } front_cfg_type;

   // residual angle in [-1/8, 1/8) turn, in 2^-32 turn
   typedef struct packed {
      quad_type                  quad;
      logic signed [TURN_W-1:0]  z;
      logic [ANGLE_W-1:0]        angle;
   } queue_entry_type;

   function automatic logic [TURN_W-1:0] atan_turn(input logic [4:0] idx);
      logic [TURN_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h2000_0000;
         5'd1:  val = 32'h12E4_051E;
         5'd2:  val = 32'h09FB_385B;
         5'd3:  val = 32'h0511_11D4;
         5'd4:  val = 32'h028B_0D43;
         5'd5:  val = 32'h0145_D7E1;
         5'd6:  val = 32'h00A2_F61E;
         5'd7:  val = 32'h0051_7C55;
         5'd8:  val = 32'h0028_BE53;
         5'd9:  val = 32'h0014_5F2F;
         5'd10: val = 32'h000A_2F98;
         5'd11: val = 32'h0005_17CC;
         5'd12: val = 32'h0002_8BE6;
         5'd13: val = 32'h0001_45F3;
         5'd14: val = 32'h0000_A2FA;
         5'd15: val = 32'h0000_517D;
         5'd16: val = 32'h0000_28BE;
         5'd17: val = 32'h0000_145F;
         5'd18: val = 32'h0000_0A30;
         5'd19: val = 32'h0000_0518;
         5'd20: val = 32'h0000_028C;
         5'd21: val = 32'h0000_0146;
         5'd22: val = 32'h0000_00A3;
         5'd23: val = 32'h0000_0051;
         5'd24: val = 32'h0000_0029;
         5'd25: val = 32'h0000_0014;
         5'd26: val = 32'h0000_000A;
         5'd27: val = 32'h0000_0005;
         5'd28: val = 32'h0000_0003;
         5'd29: val = 32'h0000_0001;
         5'd30: val = 32'h0000_0001;
         default: val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/cmo_ifs.sv
// ----------------------------------------------------------------------------
// cmo_req_if / cmo_rsp_if: valid/ready channels of the oscillator
// Request carries elapsed milliseconds, response carries position and angle.
// ----------------------------------------------------------------------------
interface cmo_req_if import cmo_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DELTA_W-1:0] delta_ms;

   modport source (output valid, output delta_ms, input ready);
   modport sink   (input valid, input delta_ms, output ready);
endinterface

interface cmo_rsp_if import cmo_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [ANGLE_W-1:0]      angle_out;

   modport source (output valid, output pos_x, output pos_y, output angle_out, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input angle_out, output ready);
endinterface

FILE: rtl/cmo_front.sv
// ----------------------------------------------------------------------------
// cmo_front: phase accumulator and angle classification
// Takes an item, advances the phase, forms the final angle and splits it
// into quadrant and residual for the rotation unit.
// ----------------------------------------------------------------------------
module cmo_front import cmo_pkg::*; #(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   cmo_req_if.sink         req_chan,
   input  front_cfg_type   cfg,
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_entry
);

   localparam int PROD_W = DELTA_W + STEP_W;

   front_state_type        state_ff, state_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PHASE_BITS-1:0]  acc_ff, acc_in;
   logic [PHASE_BITS-1:0]  ang_ff, ang_in;
   logic [PHASE_BITS-1:0]  ang_sum;
   logic [TURN_W-1:0]      ang_q32;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ang_ff  <= ang_in;
   end

   assign ang_sum = acc_ff + (PHASE_BITS'(cfg.phase_offset) << (PHASE_BITS - OFFSET_W));

   always_comb begin
      state_in       = state_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      ang_in         = ang_ff;
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               prod_in  = PROD_W'(req_chan.delta_ms) * PROD_W'(cfg.phase_step);
               state_in = F_ACC;
            end
         end
         F_ACC: begin
            // wraps modulo one turn
            acc_in   = acc_ff + prod_ff[PHASE_BITS-1:0];
            state_in = F_ANG;
         end
         F_ANG: begin
            ang_in   = cfg.clockwise ? (PHASE_BITS'(0) - ang_sum) : ang_sum;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   generate
      if (PHASE_BITS >= TURN_W) begin : g_trunc
         assign ang_q32 = ang_ff[PHASE_BITS-1 -: TURN_W];
      end else begin : g_fill
         assign ang_q32 = TURN_W'(ang_ff) << (TURN_W - PHASE_BITS);
      end
   endgenerate

   // nearest quarter turn; the rest is the low 30 bits taken as signed
   assign push_entry.quad  = quad_type'(ang_q32[31:30] + 2'(ang_q32[29]));
   assign push_entry.z     = signed'({{2{ang_q32[29]}}, ang_q32[29:0]});
   assign push_entry.angle = ang_ff[PHASE_BITS-1 -: ANGLE_W];

endmodule

FILE: rtl/cmo_queue.sv
// ----------------------------------------------------------------------------
// cmo_queue: short FIFO between classification and rotation
// Lets the front take new items while the rotation unit is busy.
// ----------------------------------------------------------------------------
module cmo_queue import cmo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type    entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/cmo_back.sv
// ----------------------------------------------------------------------------
// cmo_back: iterative sine/cosine and position scaling
// One CORDIC micro-rotation per cycle, then quadrant fix-up, scaling by
// the radius with rounding and saturation, and the response register.
// ----------------------------------------------------------------------------
module cmo_back import cmo_pkg::*; #(
   parameter int TRIG_BITS = TRIG_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  queue_entry_type  pop_entry,
   input  logic [AMP_W-1:0] amplitude,
   cmo_rsp_if.source        rsp_chan
);

   localparam int XW    = TRIG_BITS + 3;
   localparam int IW    = $clog2(TRIG_BITS);
   localparam int AMP16 = AMP_W + 5;
   localparam int PW    = AMP16 + XW;

   localparam logic [TURN_W:0] GAIN_RND =
      (TURN_W + 1)'(CORDIC_GAIN_Q32) + ((TURN_W + 1)'(1) << (TURN_W - 1 - TRIG_BITS));
   localparam logic signed [XW-1:0] X0 = XW'(GAIN_RND >> (TURN_W - TRIG_BITS));
   localparam logic signed [PW-1:0] HALF = PW'(1) << (TRIG_BITS - 1);
   localparam logic signed [PW-1:0] LIM  = PW'(POS_LIMIT);

   back_state_type           state_ff, state_in;
   logic signed [XW-1:0]     x_ff, x_in, y_ff, y_in;
   logic signed [TURN_W-1:0] z_ff, z_in;
   logic [IW-1:0]            iter_ff, iter_in;
   quad_type                 quad_ff, quad_in;
   logic [ANGLE_W-1:0]       angle_ff, angle_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [ANGLE_W-1:0]       rsp_angle_ff, rsp_angle_in;

   logic signed [XW-1:0]     dx, dy, s_val, c_val;
   logic signed [TURN_W-1:0] at;
   logic signed [AMP16-1:0]  amp16;

   function automatic logic signed [POS_W-1:0] round_sat(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] v;
      logic signed [POS_W-1:0] r;
      v = (p + HALF) >>> TRIG_BITS;
      if (v > LIM) begin
         r = POS_W'(POS_LIMIT);
      end else if (v < -LIM) begin
         r = -POS_W'(POS_LIMIT);
      end else begin
         r = POS_W'(v);
      end
      return r;
   endfunction

   assign dx    = y_ff >>> iter_ff;
   assign dy    = x_ff >>> iter_ff;
   assign at    = signed'(atan_turn(5'(iter_ff)));
   assign amp16 = signed'({1'b0, amplitude, 4'b0000});

   always_comb begin
      unique case (quad_ff)
         QUAD_0:   begin s_val = y_ff;  c_val = x_ff;  end
         QUAD_90:  begin s_val = x_ff;  c_val = -y_ff; end
         QUAD_180: begin s_val = -y_ff; c_val = -x_ff; end
         default:  begin s_val = -x_ff; c_val = y_ff;  end
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pos_x     = rsp_x_ff;
   assign rsp_chan.pos_y     = rsp_y_ff;
   assign rsp_chan.angle_out = rsp_angle_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      iter_in      = iter_ff;
      quad_in      = quad_ff;
      angle_in     = angle_ff;
      prod_in      = prod_ff;
      pos_x_in     = pos_x_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_angle_in = rsp_angle_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop_ready    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               x_in     = X0;
               y_in     = '0;
               z_in     = pop_entry.z;
               quad_in  = pop_entry.quad;
               angle_in = pop_entry.angle;
               iter_in  = '0;
               state_in = B_ROT;
            end
         end
         B_ROT: begin
            if (!z_ff[TURN_W-1]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == IW'(TRIG_BITS - 1)) begin
               state_in = B_MULS;
            end
         end
         B_MULS: begin
            prod_in  = amp16 * s_val;
            state_in = B_MULC;
         end
         B_MULC: begin
            prod_in  = amp16 * c_val;
            pos_x_in = round_sat(prod_ff);
            state_in = B_OUT;
         end
         B_OUT: begin
            // response slot is free or drains this cycle
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pos_x_ff;
               rsp_y_in     = round_sat(prod_ff);
               rsp_angle_in = angle_ff;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      iter_ff      <= iter_in;
      quad_ff      <= quad_in;
      angle_ff     <= angle_in;
      prod_ff      <= prod_in;
      pos_x_ff     <= pos_x_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_angle_ff <= rsp_angle_in;
   end

endmodule

FILE: rtl/circular_motion_oscillator.sv
// ----------------------------------------------------------------------------
// circular_motion_oscillator: quadrature oscillator moving a point on a circle
// Each request item advances the phase by delta_ms * phase_step; each
// response item gives radius*sin, radius*cos in 1/16 pixel and the angle.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries delta_ms; one response item on rsp_chan per request.
//   Registers (phase_step, amplitude, phase_offset, clockwise) are written
//   through csr_we/csr_index/csr_wdata while no item is in flight; writes to
//   an index past clockwise are dropped.
//   Between acceptance of a request and its response, an item passes the
//   phase front end (accumulate, angle, push), the queue hand-off, TRIG_BITS
//   CORDIC rotations, two scaling multiplies and the load of the response
//   register. The rotation unit sets the rate at which items complete:
//   it runs one micro-rotation per cycle and takes a new item only after
//   the last one has gone to the response register.
//   The front end and a two-entry queue keep taking items while rotation
//   runs; when rsp_chan stalls the response register holds its item and the
//   queue fills, after which req_chan.ready stays low.
//   Synchronous reset clears the phase accumulator, all registers and
//   any item in flight.
// ----------------------------------------------------------------------------
module circular_motion_oscillator import cmo_pkg::*; #(
   parameter int PHASE_BITS = PHASE_BITS_DEF,
   parameter int TRIG_BITS  = TRIG_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   cmo_req_if.sink                req_chan,
   cmo_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [STEP_W-1:0]   phase_step_ff;
   logic [AMP_W-1:0]    amplitude_ff;
   logic [OFFSET_W-1:0] phase_offset_ff;
   logic                clockwise_ff;

   front_cfg_type   front_cfg;
   logic            push_valid, push_ready;
   logic            pop_valid, pop_ready;
   queue_entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         amplitude_ff    <= '0;
         phase_offset_ff <= '0;
         clockwise_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:   phase_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_AMPLITUDE:    amplitude_ff    <= csr_wdata[AMP_W-1:0];
            CSR_PHASE_OFFSET: phase_offset_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_CLOCKWISE:    clockwise_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign front_cfg.phase_step   = phase_step_ff;
   assign front_cfg.phase_offset = phase_offset_ff;
   assign front_cfg.clockwise    = clockwise_ff;

   cmo_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (front_cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   cmo_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   cmo_back #(
      .TRIG_BITS (TRIG_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .amplitude (amplitude_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: rtl/cmo_checker.sv
// ----------------------------------------------------------------------------
// cmo_checker: port-level checks of the oscillator
// Tracks items in flight and the radius setting, bound to the top level.
// ----------------------------------------------------------------------------
module cmo_checker import cmo_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [POS_W-1:0] pos_x,
   input logic signed [POS_W-1:0] pos_y,
   input logic [ANGLE_W-1:0]      angle_out,
   input logic                    csr_we,
   input logic [CSR_INDEX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0]   csr_wdata
);

   // front end, queue, rotation unit and response register
   localparam int MAX_ITEMS = QUEUE_DEPTH + 3;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   logic [CNT_W-1:0] items_ff, items_in;
   logic             amp_zero_ff, amp_zero_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_comb begin
      items_in = items_ff;
      if (req_acc && !rsp_acc) begin
         items_in = items_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         items_in = items_ff - 1'b1;
      end
      amp_zero_in = amp_zero_ff;
      if (csr_we && (csr_index == CSR_AMPLITUDE)) begin
         amp_zero_in = (csr_wdata[AMP_W-1:0] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff    <= '0;
         amp_zero_ff <= 1'b1;
      end else begin
         items_ff    <= items_in;
         amp_zero_ff <= amp_zero_in;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pos_x) && $stable(pos_y)
                                  && $stable(angle_out))
      else $error("stalled response changed");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> items_ff != '0)
      else $error("response without a pending request");

   a_items_bounded: assert property (@(posedge clock) disable iff (reset)
      items_ff <= CNT_W'(MAX_ITEMS))
      else $error("more items in flight than storage");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && amp_zero_ff |-> pos_x == '0 && pos_y == '0)
      else $error("nonzero position at zero radius");

endmodule

bind circular_motion_oscillator cmo_checker u_cmo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .pos_x     (rsp_chan.pos_x),
   .pos_y     (rsp_chan.pos_y),
   .angle_out (rsp_chan.angle_out),
   .csr_we    (csr_we),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for circular_motion_oscillator
// Drives elapsed-time items through the request channel under random
// idling on both sides, reprograms the step, radius, offset and direction
// between phases, and checks every response against a fixed-point
// sine/cosine predictor that runs alongside the block.
// ----------------------------------------------------------------------------
module tb;
   import cmo_pkg::*;

   localparam int NUM_ITEMS  = 550;
   localparam int ROT_STEPS  = 16;
   localparam int TAIL_WAIT  = 40;
   localparam longint SAT_LIMIT = 65520;
   // starting x of the rotation: gain rounded half up to 16 fraction bits
   localparam longint ROT_START = (64'h9B74_EDA8 + 64'h8000) >> 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd4;

   // arctangent of 2^-i, in 2^-32 turn
   localparam logic [31:0] ATAN_TURN [ROT_STEPS] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
   };

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [ANGLE_W-1:0]      angle;
   } motion_point_type;

   class motion_scoreboard;
      logic [TURN_W-1:0]   phase_acc;
      logic [STEP_W-1:0]   phase_step;
      logic [AMP_W-1:0]    amplitude;
      logic [OFFSET_W-1:0] phase_offset;
      logic                clockwise;
      motion_point_type    pending[$];
      int                  errors;
      int                  checked;

      function new();
         phase_acc    = '0;
         phase_step   = '0;
         amplitude    = '0;
         phase_offset = '0;
         clockwise    = 1'b0;
         errors       = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PHASE_STEP:   phase_step   = data[STEP_W-1:0];
            CSR_AMPLITUDE:    amplitude    = data[AMP_W-1:0];
            CSR_PHASE_OFFSET: phase_offset = data[OFFSET_W-1:0];
            CSR_CLOCKWISE:    clockwise    = data[0];
            default: ;
         endcase
      endfunction

      function void sine_cosine(logic [TURN_W-1:0] ang, output longint s, output longint c);
         logic [TURN_W-1:0] rounded;
         logic [1:0]        quad;
         logic [TURN_W-1:0] resid;
         longint            x, y, z, dx, dy;
         rounded = ang + 32'h2000_0000;
         quad    = rounded[31:30];
         resid   = ang - {quad, 30'b0};
         z = longint'($signed(resid));
         x = ROT_START;
         y = 0;
         for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ATAN_TURN[i]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ATAN_TURN[i]);
            end
         end
         case (quad)
            QUAD_0:   begin s = y;  c = x;  end
            QUAD_90:  begin s = x;  c = -y; end
            QUAD_180: begin s = -y; c = -x; end
            default:  begin s = -x; c = y;  end
         endcase
      endfunction

      function logic signed [POS_W-1:0] to_sixteenths(longint t);
         longint v;
         v = (longint'(amplitude) * 16 * t + 32768) >>> 16;
         if (v > SAT_LIMIT) v = SAT_LIMIT;
         if (v < -SAT_LIMIT) v = -SAT_LIMIT;
         return v[POS_W-1:0];
      endfunction

      function void note_request(logic [DELTA_W-1:0] delta);
         logic [TURN_W-1:0] ang;
         longint            s, c;
         motion_point_type  p;
         phase_acc = phase_acc + delta * phase_step;
         ang = phase_acc + {phase_offset, 16'h0000};
         if (clockwise) ang = 32'd0 - ang;
         sine_cosine(ang, s, c);
         p.pos_x = to_sixteenths(s);
         p.pos_y = to_sixteenths(c);
         p.angle = ang[31:16];
         pending.push_back(p);
      endfunction

      function void check_response(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                   logic [ANGLE_W-1:0] a);
         motion_point_type p;
         if (pending.size() == 0) begin
            $error("response with no item outstanding: pos_x %0d pos_y %0d angle_out %0d",
                   x, y, a);
            errors++;
            return;
         end
         p = pending.pop_front();
         checked++;
         if (x !== p.pos_x) begin
            $error("pos_x: expected %0d, got %0d", p.pos_x, x);
            errors++;
         end
         if (y !== p.pos_y) begin
            $error("pos_y: expected %0d, got %0d", p.pos_y, y);
            errors++;
         end
         if (a !== p.angle) begin
            $error("angle_out: expected %0d, got %0d", p.angle, a);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   calm;
   int                     items_sent;
   int                     settings_used;

   cmo_req_if req_chan();
   cmo_rsp_if rsp_chan();

   circular_motion_oscillator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   motion_scoreboard track = new();

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // observe accepted items, register writes and responses
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) track.write_reg(csr_index, csr_wdata);
         if (req_chan.valid && req_chan.ready) track.note_request(req_chan.delta_ms);
         if (rsp_chan.valid && rsp_chan.ready)
            track.check_response(rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.angle_out);
      end
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 26);
      end
   end

   task automatic send_delta(input logic [DELTA_W-1:0] d);
      while (!calm && $urandom_range(99) < 26) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.delta_ms <= d;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // waits for the block to drain, then writes all four registers and one
   // unmapped index, which must be ignored
   task automatic program_regs(input logic [STEP_W-1:0] step, input logic [AMP_W-1:0] amp,
                               input logic [OFFSET_W-1:0] offset, input logic cw);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      logic [CSR_DATA_W-1:0]  junk;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (track.pending.size() != 0) @(posedge clock);
      // upper bits beyond each register's width are random and must be dropped
      junk = $urandom;
      idx[0] = CSR_PHASE_STEP;   val[0] = step;
      idx[1] = CSR_AMPLITUDE;    val[1] = {junk[31:AMP_W], amp};
      idx[2] = CSR_PHASE_OFFSET; val[2] = {junk[31:OFFSET_W], offset};
      idx[3] = CSR_CLOCKWISE;    val[3] = {junk[31:1], cw};
      idx[4] = CSR_UNMAPPED | CSR_INDEX_W'($urandom_range(3));
      val[4] = $urandom;
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [DELTA_W-1:0] pick_delta();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return DELTA_W'($urandom_range(20));
         default: return DELTA_W'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_W-1:0] pick_step();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return STEP_W'($urandom_range(1, 1 << 20));
         3:       return {2'($urandom_range(3)), 30'b0};
         default: return STEP_W'($urandom);
      endcase
   endfunction

   function automatic logic [AMP_W-1:0] pick_amp();
      case ($urandom_range(7))
         0:       return '0;
         1, 2:    return '1;
         default: return AMP_W'($urandom);
      endcase
   endfunction

   initial begin
      int n;
      int phase_no;
      logic [OFFSET_W-1:0] offset;
      reset             <= 1'b1;
      calm              <= 1'b0;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.delta_ms <= '0;
      items_sent    = 0;
      settings_used = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // zero radius: positions stay at the center whatever the angle
      program_regs(32'h1234_5678, '0, 16'h3C00, 1'b0);
      send_delta('0);
      send_delta('1);
      send_delta(16'd1);
      // full radius, quarter turn per ms: lands on every quadrant boundary
      program_regs(32'h4000_0000, '1, '0, 1'b0);
      for (int i = 0; i < 5; i++) send_delta(16'd1);
      send_delta('0);
      // largest step, offset and delta, clockwise: accumulator wraps
      program_regs('1, '1, '1, 1'b1);
      send_delta('1);
      send_delta('1);
      send_delta('0);
      send_delta(16'd2);
      // eighth-turn steps, at small and large radius and in both directions
      program_regs(32'h2000_0000, 12'd1, 16'h1000, 1'b0);
      for (int i = 0; i < 4; i++) send_delta(16'd1);
      program_regs(32'h2000_0000, 12'd2047, 16'hE000, 1'b1);
      for (int i = 0; i < 4; i++) send_delta(16'd1);

      phase_no = 0;
      while (items_sent < NUM_ITEMS) begin
         offset = ($urandom_range(4) == 0) ? OFFSET_W'({OFFSET_W{$urandom_range(1) == 1}})
                                          : OFFSET_W'($urandom);
         program_regs(pick_step(), pick_amp(), offset, 1'($urandom));
         // one long phase runs with both sides streaming
         calm <= (phase_no == 3);
         n = (phase_no == 3) ? 80 : $urandom_range(20, 60);
         for (int i = 0; i < n; i++) send_delta(pick_delta());
         calm <= 1'b0;
         phase_no++;
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (track.pending.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Run covered %0d items under %0d register settings; %0d responses checked.",
               items_sent, settings_used, track.checked);
      if (track.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d items still outstanding", track.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
rtl/cmo_pkg.sv
rtl/cmo_ifs.sv
rtl/cmo_front.sv
rtl/cmo_queue.sv
rtl/cmo_back.sv
rtl/circular_motion_oscillator.sv
rtl/cmo_checker.sv
sim/tb.sv
